// ===== hdl/fcr_pkg.sv =====
`timescale 1ns / 1ps

package fcr_pkg;

  localparam int RADIUS_BITS = 12;
  localparam int IN_RADIUS_W = 12;
  localparam int CENTER_W    = 16;
  localparam int COORD_W     = 17;
  localparam int COLOR_W     = 32;
  localparam int OFS_W       = RADIUS_BITS + 2;
  localparam int DEC_W       = RADIUS_BITS + 3;
  localparam int JOB_DEPTH   = 2;
  localparam int JOB_PTR_W   = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int JOB_CNT_W   = $clog2(JOB_DEPTH + 1);

  typedef logic        [RADIUS_BITS-1:0] rad_t;
  typedef logic signed [OFS_W-1:0]       ofs_t;
  typedef logic signed [DEC_W-1:0]       dec_t;
  typedef logic signed [CENTER_W-1:0]    center_t;
  typedef logic signed [COORD_W-1:0]     coord_t;
  typedef logic        [COLOR_W-1:0]     color_t;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_POINT = 1'b0,
    KIND_SPAN  = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    SLOT_PT0   = 4'd0,
    SLOT_PT1   = 4'd1,
    SLOT_PT2   = 4'd2,
    SLOT_PT3   = 4'd3,
    SLOT_PT4   = 4'd4,
    SLOT_PT5   = 4'd5,
    SLOT_PT6   = 4'd6,
    SLOT_PT7   = 4'd7,
    SLOT_SPAN0 = 4'd8,
    SLOT_SPAN1 = 4'd9,
    SLOT_SPAN2 = 4'd10,
    SLOT_SPAN3 = 4'd11
  } slot_e;

  typedef struct packed {
    center_t cx;
    center_t cy;
    ofs_t    ox;
    ofs_t    oy;
    logic    done;
  } job_t;

endpackage

// ===== hdl/fcr_front.sv =====
`timescale 1ns / 1ps

module fcr_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic                              cmd_i,
  input  logic signed [15:0]                center_x_i,
  input  logic signed [15:0]                center_y_i,
  input  logic [fcr_pkg::IN_RADIUS_W-1:0]   circle_radius_i,
  output logic                              job_push_o,
  output fcr_pkg::job_t                     job_o
);

  logic              active_q, active_d;
  fcr_pkg::ofs_t     ox_q, ox_d, oy_q, oy_d;
  fcr_pkg::dec_t     dec_q, dec_d;
  fcr_pkg::center_t  cx_q, cx_d, cy_q, cy_d;
  fcr_pkg::rad_t     rad_q, rad_d;

  logic              start;
  logic              do_iter;
  fcr_pkg::rad_t     in_rad;
  fcr_pkg::ofs_t     eff_ox, eff_oy, eff_r, new_ox, new_oy;
  fcr_pkg::dec_t     eff_d, two_ox, lim, new_d;
  fcr_pkg::center_t  eff_cx, eff_cy;

  always_comb begin
    start   = (fcr_pkg::cmd_e'(cmd_i) == fcr_pkg::CMD_START);
    do_iter = start || active_q;
    in_rad  = fcr_pkg::rad_t'(circle_radius_i);

    eff_r  = start ? fcr_pkg::ofs_t'(in_rad) : fcr_pkg::ofs_t'(rad_q);
    eff_ox = start ? '0 : ox_q;
    eff_oy = start ? eff_r : oy_q;
    eff_d  = start ? fcr_pkg::dec_t'(eff_r) - fcr_pkg::dec_t'(1) : dec_q;
    eff_cx = start ? center_x_i : cx_q;
    eff_cy = start ? center_y_i : cy_q;

    two_ox = fcr_pkg::dec_t'(eff_ox) + fcr_pkg::dec_t'(eff_ox);
    lim    = fcr_pkg::dec_t'(eff_r) - fcr_pkg::dec_t'(eff_oy);

    priority if (eff_d >= two_ox) begin
      new_d  = eff_d - two_ox - fcr_pkg::dec_t'(1);
      new_ox = eff_ox + fcr_pkg::ofs_t'(1);
      new_oy = eff_oy;
    end else if (eff_d < lim + lim) begin
      new_d  = eff_d + fcr_pkg::dec_t'(eff_oy) + fcr_pkg::dec_t'(eff_oy)
               - fcr_pkg::dec_t'(1);
      new_ox = eff_ox;
      new_oy = eff_oy - fcr_pkg::ofs_t'(1);
    end else begin
      new_d  = eff_d + fcr_pkg::dec_t'(eff_oy) + fcr_pkg::dec_t'(eff_oy)
               - two_ox - fcr_pkg::dec_t'(2);
      new_ox = eff_ox + fcr_pkg::ofs_t'(1);
      new_oy = eff_oy - fcr_pkg::ofs_t'(1);
    end

    active_d = active_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    dec_d    = dec_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    rad_d    = rad_q;
    if (accept_i && do_iter) begin
      active_d = !(new_oy < new_ox);
      ox_d     = new_ox;
      oy_d     = new_oy;
      dec_d    = new_d;
      cx_d     = eff_cx;
      cy_d     = eff_cy;
      rad_d    = start ? in_rad : rad_q;
    end

    job_push_o = accept_i && do_iter;
    job_o.cx   = eff_cx;
    job_o.cy   = eff_cy;
    job_o.ox   = eff_ox;
    job_o.oy   = eff_oy;
    job_o.done = new_oy < new_ox;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ox_q     <= '0;
      oy_q     <= '0;
      dec_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      rad_q    <= '0;
    end else begin
      active_q <= active_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      dec_q    <= dec_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      rad_q    <= rad_d;
    end
  end

endmodule

// ===== hdl/fcr_job_fifo.sv =====
`timescale 1ns / 1ps

module fcr_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  fcr_pkg::job_t  wr_data_i,
  output logic           full_o,
  output logic           rd_valid_o,
  output fcr_pkg::job_t  rd_data_o,
  input  logic           rd_en_i
);

  fcr_pkg::job_t                  mem_q [fcr_pkg::JOB_DEPTH];
  logic [fcr_pkg::JOB_PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [fcr_pkg::JOB_CNT_W-1:0]  cnt_q, cnt_d;

  function automatic logic [fcr_pkg::JOB_PTR_W-1:0] ptr_next(
    input logic [fcr_pkg::JOB_PTR_W-1:0] p
  );
    if (p == fcr_pkg::JOB_PTR_W'(fcr_pkg::JOB_DEPTH - 1)) begin
      return '0;
    end
    return p + fcr_pkg::JOB_PTR_W'(1);
  endfunction

  always_comb begin
    full_o     = (cnt_q == fcr_pkg::JOB_CNT_W'(fcr_pkg::JOB_DEPTH));
    rd_valid_o = (cnt_q != '0);
    rd_data_o  = mem_q[rd_ptr_q];
    wr_ptr_d   = wr_en_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d   = rd_en_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d      = cnt_q + fcr_pkg::JOB_CNT_W'(wr_en_i) - fcr_pkg::JOB_CNT_W'(rd_en_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== hdl/fcr_back.sv =====
`timescale 1ns / 1ps

module fcr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  fcr_pkg::job_t          job_i,
  output logic                   job_pop_o,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic                   item_kind_o,
  output fcr_pkg::coord_t        x_begin_o,
  output fcr_pkg::coord_t        x_finish_o,
  output fcr_pkg::coord_t        y_coord_o,
  output logic                   last_of_step_o,
  output logic                   circle_done_o
);

  fcr_pkg::slot_e   slot_q, slot_d;
  logic             ovalid_q, ovalid_d;
  logic             kind_q, last_q, done_q;
  fcr_pkg::coord_t  xb_q, xf_q, y_q;

  logic             out_load;
  fcr_pkg::kind_e   kind_n;
  fcr_pkg::coord_t  xb_n, xf_n, y_n;
  fcr_pkg::coord_t  cx, cy, oa, ob;
  fcr_pkg::coord_t  cxa_p, cxa_m, cxb_p, cxb_m, cya_p, cya_m, cyb_p, cyb_m;

  always_comb begin
    cx    = fcr_pkg::coord_t'(job_i.cx);
    cy    = fcr_pkg::coord_t'(job_i.cy);
    oa    = fcr_pkg::coord_t'(job_i.ox);
    ob    = fcr_pkg::coord_t'(job_i.oy);
    cxa_p = cx + oa;
    cxa_m = cx - oa;
    cxb_p = cx + ob;
    cxb_m = cx - ob;
    cya_p = cy + oa;
    cya_m = cy - oa;
    cyb_p = cy + ob;
    cyb_m = cy - ob;

    kind_n = fcr_pkg::KIND_POINT;
    unique case (slot_q)
      fcr_pkg::SLOT_PT0:   begin xb_n = cxa_p; xf_n = cxa_p; y_n = cyb_p; end
      fcr_pkg::SLOT_PT1:   begin xb_n = cxb_p; xf_n = cxb_p; y_n = cya_p; end
      fcr_pkg::SLOT_PT2:   begin xb_n = cxa_m; xf_n = cxa_m; y_n = cyb_p; end
      fcr_pkg::SLOT_PT3:   begin xb_n = cxb_m; xf_n = cxb_m; y_n = cya_p; end
      fcr_pkg::SLOT_PT4:   begin xb_n = cxa_p; xf_n = cxa_p; y_n = cyb_m; end
      fcr_pkg::SLOT_PT5:   begin xb_n = cxb_p; xf_n = cxb_p; y_n = cya_m; end
      fcr_pkg::SLOT_PT6:   begin xb_n = cxa_m; xf_n = cxa_m; y_n = cyb_m; end
      fcr_pkg::SLOT_PT7:   begin xb_n = cxb_m; xf_n = cxb_m; y_n = cya_m; end
      fcr_pkg::SLOT_SPAN0: begin
        kind_n = fcr_pkg::KIND_SPAN; xb_n = cxb_m; xf_n = cxb_p; y_n = cya_p;
      end
      fcr_pkg::SLOT_SPAN1: begin
        kind_n = fcr_pkg::KIND_SPAN; xb_n = cxa_m; xf_n = cxa_p; y_n = cyb_p;
      end
      fcr_pkg::SLOT_SPAN2: begin
        kind_n = fcr_pkg::KIND_SPAN; xb_n = cxa_m; xf_n = cxa_p; y_n = cyb_m;
      end
      fcr_pkg::SLOT_SPAN3: begin
        kind_n = fcr_pkg::KIND_SPAN; xb_n = cxb_m; xf_n = cxb_p; y_n = cya_m;
      end
      default:             begin xb_n = cxa_p; xf_n = cxa_p; y_n = cyb_p; end
    endcase

    out_load  = job_valid_i && (!ovalid_q || pop_i);
    job_pop_o = out_load && (slot_q == fcr_pkg::SLOT_SPAN3);

    slot_d = slot_q;
    if (out_load) begin
      slot_d = job_pop_o ? fcr_pkg::SLOT_PT0 : fcr_pkg::slot_e'(slot_q + 4'd1);
    end

    ovalid_d = ovalid_q;
    if (out_load) begin
      ovalid_d = 1'b1;
    end else if (pop_i) begin
      ovalid_d = 1'b0;
    end

    empty_o        = !ovalid_q;
    item_kind_o    = kind_q;
    x_begin_o      = xb_q;
    x_finish_o     = xf_q;
    y_coord_o      = y_q;
    last_of_step_o = last_q;
    circle_done_o  = done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= fcr_pkg::SLOT_PT0;
      ovalid_q <= 1'b0;
    end else begin
      slot_q   <= slot_d;
      ovalid_q <= ovalid_d;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q <= kind_n;
      xb_q   <= xb_n;
      xf_q   <= xf_n;
      y_q    <= y_n;
      last_q <= job_pop_o;
      done_q <= job_pop_o && job_i.done;
    end
  end

endmodule

// ===== hdl/filled_circle_rasterizer.sv =====
`timescale 1ns / 1ps

// Filled circle rasterizer.
// Input queue side: drive cmd_i with centre and radius and raise push; a beat
// is taken at a clock edge with push high and full low. A start beat begins
// a new circle, an advance beat runs its next iteration; an advance while no
// circle is active is taken and yields nothing.
// Result queue side: while empty is low the oldest result sits on the ports;
// it is taken at an edge with pop high. Each iteration yields twelve results:
// eight boundary points, then four spans, the last flagged and, at the end
// of the circle, marked done.
// The expander registers each result from the job queue; the result side
// delivers one beat per cycle while pop is high and a job is queued; the
// output expander is the pacing unit. A two-entry job queue between the
// decision logic and the expander lets input beats be taken meanwhile.
// When pop stays low the result holds, the expander halts, the job queue
// fills and full rises. Reset empties both queues, ends any circle and sets
// the colour to all ones. Colour is written on the cfg channel (always ready).
module filled_circle_rasterizer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic                             cmd_i,
  input  logic signed [15:0]               center_x_i,
  input  logic signed [15:0]               center_y_i,
  input  logic [fcr_pkg::IN_RADIUS_W-1:0]  circle_radius_i,
  output logic                             empty,
  input  logic                             pop,
  output logic                             item_kind_o,
  output logic signed [16:0]               x_begin_o,
  output logic signed [16:0]               x_finish_o,
  output logic signed [16:0]               y_coord_o,
  output logic [31:0]                      pixel_color_o,
  output logic                             last_of_step_o,
  output logic                             circle_done_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [31:0]                      cfg_wdata_i
);

  fcr_pkg::color_t  color_q;
  logic             in_accept;
  logic             job_push, job_pop, job_valid, job_full, res_empty;
  fcr_pkg::job_t    job_in, job_out;

  assign cfg_ready_o   = 1'b1;
  assign full          = job_full;
  assign empty         = res_empty;
  assign in_accept     = push && !job_full;
  assign pixel_color_o = color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      color_q <= cfg_wdata_i;
    end
  end

  fcr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .cmd_i           (cmd_i),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .circle_radius_i (circle_radius_i),
    .job_push_o      (job_push),
    .job_o           (job_in)
  );

  fcr_job_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (job_push),
    .wr_data_i  (job_in),
    .full_o     (job_full),
    .rd_valid_o (job_valid),
    .rd_data_o  (job_out),
    .rd_en_i    (job_pop)
  );

  fcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .empty_o        (res_empty),
    .pop_i          (pop),
    .item_kind_o    (item_kind_o),
    .x_begin_o      (x_begin_o),
    .x_finish_o     (x_finish_o),
    .y_coord_o      (y_coord_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

`ifndef SYNTH
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!res_empty && circle_done_o) |-> last_of_step_o)
    else $error("done flag on a result that is not the last of its step");

  a_point_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!res_empty && item_kind_o == fcr_pkg::KIND_POINT) |-> (x_begin_o == x_finish_o))
    else $error("point result with differing ends");

  a_start_queues_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && cmd_i == fcr_pkg::CMD_START) |=> job_valid)
    else $error("start beat left no job queued");

  a_pop_at_step_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |=> (!res_empty && last_of_step_o))
    else $error("job released without its last result");
`endif

endmodule
